/* design/slfr_pkg.sv */
// slfr_pkg: shared types and byte codes of the stuffed length frame receiver
package slfr_pkg;

    // framing byte codes
    localparam logic [7:0] SOF_BYTE = 8'hA3;
    localparam logic [7:0] EOF_BYTE = 8'hA4;
    localparam logic [7:0] ESC_BYTE = 8'h1B;

    // codes that follow an escape byte
    localparam logic [7:0] SOF_CODE = 8'h01;
    localparam logic [7:0] EOF_CODE = 8'h02;
    localparam logic [7:0] ESC_CODE = 8'h03;

    // reset value of the length limit
    localparam logic [15:0] MAX_LEN_RESET = 16'd1000;

    // framing phase
    typedef enum logic [2:0] {
        PH_SOF     = 3'd0,
        PH_LEN_LO  = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_EOF     = 3'd4
    } phase_t;

    // event kinds on the result channel
    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_DONE = 2'd1,
        KIND_DROP = 2'd2
    } kind_t;

    // received word
    typedef struct packed {
        logic [7:0] rx_byte;
    } rx_word_t;

    // event word
    typedef struct packed {
        kind_t       event_kind;
        logic [7:0]  payload_byte;
        logic [15:0] frame_length;
    } evt_word_t;

endpackage

/* design/slfr_stream_if.sv */
// slfr_stream_if: valid/ready channel carrying one word of a given type
interface slfr_stream_if #(
    parameter type word_t = logic [7:0]
);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* design/stuffed_length_frame_receiver_unit.sv */
// stuffed_length_frame_receiver_unit: byte unstuffing, framing and event output
//
//  channel | dir | word            | notes
//  --------+-----+-----------------+-----------------------------------------
//  rx      | in  | rx_byte[7:0]    | one raw link byte per word
//  evt     | out | kind/byte/len   | payload byte, frame done or frame drop
//  cfg     | in  | data[15:0]      | max_frame_length, always ready
//
// One word per cycle while rx ready is high: the framing state updates in the
// accept cycle and the event lands in the output register, or in the skid
// register behind it while the output word waits. The skid register keeps rx
// ready while one event waits; rx ready drops only while it is occupied.
// Reset (rst_n low, asynchronous) returns the framer to waiting for start of
// frame, clears both event valid flags and loads the length limit with 1000.
module stuffed_length_frame_receiver_unit (
    input  logic          clk,
    input  logic          rst_n,
    slfr_stream_if.sink   rx,
    slfr_stream_if.source evt,
    slfr_stream_if.sink   cfg
);

    // framing state
    slfr_pkg::phase_t    phase_reg, phase_next;
    logic                esc_reg, esc_next;
    logic [15:0]         len_reg, len_next;
    logic [15:0]         rem_reg, rem_next;
    logic [15:0]         max_len_reg;

    // output and skid registers
    logic                out_valid_reg, out_valid_next;
    slfr_pkg::evt_word_t out_data_reg, out_data_next;
    logic                skid_valid_reg, skid_valid_next;
    slfr_pkg::evt_word_t skid_data_reg, skid_data_next;

    // result of the current word
    logic                res_valid;
    slfr_pkg::evt_word_t res;
    logic                acc;

    assign rx.ready  = !skid_valid_reg;
    assign acc       = rx.valid && rx.ready;
    assign cfg.ready = 1'b1;
    assign evt.valid = out_valid_reg;
    assign evt.data  = out_data_reg;

    // length limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= slfr_pkg::MAX_LEN_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            max_len_reg <= cfg.data;
        end
    end

    // framing state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= slfr_pkg::PH_SOF;
            esc_reg   <= 1'b0;
            len_reg   <= '0;
            rem_reg   <= '0;
        end
        else if (acc)
        begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            len_reg   <= len_next;
            rem_reg   <= rem_next;
        end
    end

    // next framing state and event for the incoming word
    always_comb
    begin
        logic [7:0]       ch;
        slfr_pkg::phase_t ph;
        logic             skip;
        logic [15:0]      len_full;

        ch         = rx.data.rx_byte;
        ph         = phase_reg;
        skip       = 1'b0;
        len_full   = {ch, len_reg[7:0]};
        phase_next = phase_reg;
        esc_next   = esc_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        res_valid  = 1'b0;
        res        = '{event_kind: slfr_pkg::KIND_BYTE, payload_byte: 8'h00,
                       frame_length: 16'h0000};

        // raw start of frame restarts framing
        if (ch == slfr_pkg::SOF_BYTE)
        begin
            esc_next = 1'b0;
            if (ph != slfr_pkg::PH_SOF)
            begin
                res_valid      = 1'b1;
                res.event_kind = slfr_pkg::KIND_DROP;
            end
            ph         = slfr_pkg::PH_SOF;
            phase_next = slfr_pkg::PH_SOF;
        end

        // escape handling and unstuffing
        if (ch == slfr_pkg::ESC_BYTE)
        begin
            esc_next = 1'b1;
            skip     = 1'b1;
        end
        else if (esc_reg && (ch != slfr_pkg::SOF_BYTE))
        begin
            esc_next = 1'b0;
            case (ch)
                slfr_pkg::SOF_CODE: ch = slfr_pkg::SOF_BYTE;
                slfr_pkg::EOF_CODE: ch = slfr_pkg::EOF_BYTE;
                slfr_pkg::ESC_CODE: ch = slfr_pkg::ESC_BYTE;
                default:
                begin
                    skip = 1'b1;
                    if (ph != slfr_pkg::PH_SOF)
                    begin
                        res_valid      = 1'b1;
                        res.event_kind = slfr_pkg::KIND_DROP;
                    end
                    phase_next = slfr_pkg::PH_SOF;
                end
            endcase
            len_full = {ch, len_reg[7:0]};
        end

        // phase step on the unstuffed byte
        if (!skip)
        begin
            case (ph)
                slfr_pkg::PH_LEN_LO:
                begin
                    len_next   = {8'h00, ch};
                    phase_next = slfr_pkg::PH_LEN_HI;
                end
                slfr_pkg::PH_LEN_HI:
                begin
                    len_next = len_full;
                    rem_next = len_full;
                    if (len_full == 16'h0000)
                    begin
                        phase_next = slfr_pkg::PH_EOF;
                    end
                    else if (len_full > max_len_reg)
                    begin
                        phase_next     = slfr_pkg::PH_SOF;
                        res_valid      = 1'b1;
                        res.event_kind = slfr_pkg::KIND_DROP;
                    end
                    else
                    begin
                        phase_next = slfr_pkg::PH_PAYLOAD;
                    end
                end
                slfr_pkg::PH_PAYLOAD:
                begin
                    res_valid        = 1'b1;
                    res.event_kind   = slfr_pkg::KIND_BYTE;
                    res.payload_byte = ch;
                    rem_next         = rem_reg - 16'd1;
                    if (rem_reg == 16'd1)
                    begin
                        phase_next = slfr_pkg::PH_EOF;
                    end
                end
                slfr_pkg::PH_EOF:
                begin
                    res_valid = 1'b1;
                    if (ch == slfr_pkg::EOF_BYTE)
                    begin
                        res.event_kind   = slfr_pkg::KIND_DONE;
                        res.frame_length = len_reg;
                    end
                    else
                    begin
                        res.event_kind = slfr_pkg::KIND_DROP;
                    end
                    phase_next = slfr_pkg::PH_SOF;
                end
                default:
                begin
                    if (ch == slfr_pkg::SOF_BYTE)
                    begin
                        phase_next = slfr_pkg::PH_LEN_LO;
                    end
                end
            endcase
        end
    end

    // output register with skid stage
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || evt.ready)
        begin
            out_valid_next  = skid_valid_reg || (acc && res_valid);
            out_data_next   = skid_valid_reg ? skid_data_reg : res;
            skid_valid_next = 1'b0;
        end
        else if (acc && res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    // output control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // output payload registers
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // skid stage is only filled behind a waiting output word
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held without output word");

    // payload phase always has bytes left
    a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == slfr_pkg::PH_PAYLOAD) |-> (rem_reg != 16'd0))
        else $error("payload phase with no bytes remaining");

    // in the payload phase the remaining count never exceeds the frame length
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == slfr_pkg::PH_PAYLOAD) |-> (rem_reg <= len_reg))
        else $error("remaining count above frame length");

    // payload words come only from the payload phase
    a_byte_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && res_valid && (res.event_kind == slfr_pkg::KIND_BYTE))
            |-> (phase_reg == slfr_pkg::PH_PAYLOAD))
        else $error("payload word outside payload phase");

    // a completed frame reports the stored length
    a_done_len: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && res_valid && (res.event_kind == slfr_pkg::KIND_DONE))
            |-> ((phase_reg == slfr_pkg::PH_EOF) && (res.frame_length == len_reg)))
        else $error("frame done with wrong length or phase");

endmodule

/* dv/tb.sv */
// tb: randomized self-checking bench for the stuffed length frame receiver
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 400_000;
    localparam int unsigned SEGMENT_WORDS = 480;

    // hand-picked opening sequence: every event kind and framing corner
    localparam logic [7:0] DIRECTED_BYTES [0:26] = '{
        // one-byte frame carrying 0xff
        slfr_pkg::SOF_BYTE, 8'h01, 8'h00, 8'hFF, slfr_pkg::EOF_BYTE,
        // two stuffed payload bytes behind a double escape, stuffed end byte
        slfr_pkg::SOF_BYTE, 8'h02, 8'h00,
        slfr_pkg::ESC_BYTE, slfr_pkg::ESC_BYTE, slfr_pkg::ESC_CODE,
        slfr_pkg::ESC_BYTE, slfr_pkg::SOF_CODE, slfr_pkg::ESC_BYTE, slfr_pkg::EOF_CODE,
        // zero length, then a raw start byte where the end byte belongs
        slfr_pkg::SOF_BYTE, 8'h00, 8'h00, slfr_pkg::SOF_BYTE,
        // that frame hits a bad escape code in its payload
        8'h01, 8'h00, slfr_pkg::ESC_BYTE, 8'h55,
        // stuffed start byte opens a frame longer than the reset limit
        slfr_pkg::ESC_BYTE, slfr_pkg::SOF_CODE, 8'hE9, 8'h03
    };

    logic clk = 1'b0;
    logic rst_n;

    slfr_stream_if #(.word_t(slfr_pkg::rx_word_t))  rx_if ();
    slfr_stream_if #(.word_t(slfr_pkg::evt_word_t)) evt_if ();
    slfr_stream_if #(.word_t(logic [15:0]))         cfg_if ();

    stuffed_length_frame_receiver_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .evt   (evt_if),
        .cfg   (cfg_if)
    );

    // bench copy of the framer state and the length limit
    slfr_pkg::phase_t    frame_phase;
    logic                escape_seen;
    logic [15:0]         frame_len;
    logic [15:0]         len_left;
    logic [15:0]         limit_len;

    logic [7:0]          link_bytes [$];
    slfr_pkg::evt_word_t pending_events [$];
    int unsigned         send_idle_pct;
    int unsigned         stall_pct;
    int unsigned         mismatch_count;
    int unsigned         cycle_count;

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // framer prediction for one accepted link byte, returns 1 when an event follows
    function automatic bit deframe_byte(input logic [7:0] raw,
                                        output slfr_pkg::evt_word_t ev);
        logic [7:0] ch;
        bit         fired;
        ch = raw;
        fired = 1'b0;
        ev = '0;
        // raw start byte always restarts framing
        if (ch == slfr_pkg::SOF_BYTE)
        begin
            escape_seen = 1'b0;
            if (frame_phase != slfr_pkg::PH_SOF)
            begin
                ev.event_kind = slfr_pkg::KIND_DROP;
                fired = 1'b1;
            end
            frame_phase = slfr_pkg::PH_SOF;
        end
        // escape byte, a repeated one just keeps the flag
        if (ch == slfr_pkg::ESC_BYTE)
        begin
            escape_seen = 1'b1;
            return fired;
        end
        // unstuffing
        if (escape_seen)
        begin
            escape_seen = 1'b0;
            if (ch == slfr_pkg::SOF_CODE)
                ch = slfr_pkg::SOF_BYTE;
            else if (ch == slfr_pkg::EOF_CODE)
                ch = slfr_pkg::EOF_BYTE;
            else if (ch == slfr_pkg::ESC_CODE)
                ch = slfr_pkg::ESC_BYTE;
            else
            begin
                if (frame_phase != slfr_pkg::PH_SOF)
                begin
                    ev.event_kind = slfr_pkg::KIND_DROP;
                    fired = 1'b1;
                end
                frame_phase = slfr_pkg::PH_SOF;
                return fired;
            end
        end
        // framing
        case (frame_phase)
            slfr_pkg::PH_LEN_LO:
            begin
                frame_len = {8'h00, ch};
                frame_phase = slfr_pkg::PH_LEN_HI;
            end
            slfr_pkg::PH_LEN_HI:
            begin
                frame_len = {ch, frame_len[7:0]};
                len_left = frame_len;
                if (frame_len == 16'd0)
                    frame_phase = slfr_pkg::PH_EOF;
                else if (frame_len > limit_len)
                begin
                    frame_phase = slfr_pkg::PH_SOF;
                    ev.event_kind = slfr_pkg::KIND_DROP;
                    fired = 1'b1;
                end
                else
                    frame_phase = slfr_pkg::PH_PAYLOAD;
            end
            slfr_pkg::PH_PAYLOAD:
            begin
                ev.event_kind = slfr_pkg::KIND_BYTE;
                ev.payload_byte = ch;
                fired = 1'b1;
                len_left = len_left - 16'd1;
                if (len_left == 16'd0)
                    frame_phase = slfr_pkg::PH_EOF;
            end
            slfr_pkg::PH_EOF:
            begin
                if (ch == slfr_pkg::EOF_BYTE)
                begin
                    ev.event_kind = slfr_pkg::KIND_DONE;
                    ev.frame_length = frame_len;
                end
                else
                    ev.event_kind = slfr_pkg::KIND_DROP;
                fired = 1'b1;
                frame_phase = slfr_pkg::PH_SOF;
            end
            default:
            begin
                if (ch == slfr_pkg::SOF_BYTE)
                    frame_phase = slfr_pkg::PH_LEN_LO;
            end
        endcase
        return fired;
    endfunction

    function automatic void report_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] error: %s", $realtime, msg);
    endfunction

    // stuff one value onto the link, sometimes with a redundant escape
    task automatic push_stuffed(input logic [7:0] value);
        if (value == slfr_pkg::SOF_BYTE || value == slfr_pkg::EOF_BYTE
            || value == slfr_pkg::ESC_BYTE)
        begin
            link_bytes.push_back(slfr_pkg::ESC_BYTE);
            if ($urandom_range(0, 99) < 15)
                link_bytes.push_back(slfr_pkg::ESC_BYTE);
            if (value == slfr_pkg::SOF_BYTE)
                link_bytes.push_back(slfr_pkg::SOF_CODE);
            else if (value == slfr_pkg::EOF_BYTE)
                link_bytes.push_back(slfr_pkg::EOF_CODE);
            else
                link_bytes.push_back(slfr_pkg::ESC_CODE);
        end
        else
            link_bytes.push_back(value);
    endtask

    // one mostly well-formed frame with random content and occasional damage
    task automatic queue_frame();
        int unsigned lim;
        int unsigned len;
        int unsigned roll;
        lim = limit_len;
        roll = $urandom_range(0, 99);
        if (roll < 8 && lim < 65535)
            len = $urandom_range(lim + 1, 65535);
        else if (roll < 14 && lim <= 64)
            len = lim;
        else
            len = $urandom_range(0, 12);
        // line noise between frames
        if ($urandom_range(0, 99) < 12)
            repeat ($urandom_range(1, 3)) link_bytes.push_back(8'($urandom_range(0, 255)));
        // start byte, raw or stuffed
        if ($urandom_range(0, 99) < 10)
        begin
            link_bytes.push_back(slfr_pkg::ESC_BYTE);
            link_bytes.push_back(slfr_pkg::SOF_CODE);
        end
        else
            link_bytes.push_back(slfr_pkg::SOF_BYTE);
        push_stuffed(8'(len));
        push_stuffed(8'(len >> 8));
        if (len > lim)
            return;
        // payload
        for (int unsigned i = 0; i < len; i++)
        begin
            roll = $urandom_range(0, 199);
            if (roll < 3)
                return;
            if (roll < 5)
            begin
                link_bytes.push_back(slfr_pkg::ESC_BYTE);
                link_bytes.push_back(8'($urandom_range(0, 255)));
            end
            push_stuffed(8'($urandom_range(0, 255)));
        end
        // end byte: raw, stuffed or wrong
        roll = $urandom_range(0, 99);
        if (roll < 6)
            link_bytes.push_back(8'($urandom_range(0, 255)));
        else if (roll < 16)
        begin
            link_bytes.push_back(slfr_pkg::ESC_BYTE);
            link_bytes.push_back(slfr_pkg::EOF_CODE);
        end
        else
            link_bytes.push_back(slfr_pkg::EOF_BYTE);
    endtask

    // wait until every word is taken and every event is back, then settle
    task automatic wait_drained(input int unsigned settle);
        do
            @(negedge clk);
        while (link_bytes.size() != 0 || rx_if.valid || pending_events.size() != 0);
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_max_len(input logic [15:0] value);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        limit_len = value;
    endtask

    task automatic fill_segment();
        @(negedge clk);
        while (link_bytes.size() < SEGMENT_WORDS)
            queue_frame();
    endtask

    // rx driver with random idle cycles
    always @(posedge clk)
    begin : rx_driver
        slfr_pkg::evt_word_t ev;
        if (rst_n)
        begin
            if (rx_if.valid && rx_if.ready)
            begin
                if (deframe_byte(rx_if.data.rx_byte, ev))
                    pending_events.push_back(ev);
            end
            if (!rx_if.valid || rx_if.ready)
            begin
                if (link_bytes.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    rx_if.valid <= 1'b1;
                    rx_if.data.rx_byte <= link_bytes.pop_front();
                end
                else
                    rx_if.valid <= 1'b0;
            end
        end
    end

    // event monitor with random back pressure
    always @(posedge clk)
    begin : evt_monitor
        slfr_pkg::evt_word_t want;
        slfr_pkg::evt_word_t seen;
        if (rst_n)
        begin
            if (evt_if.valid && evt_if.ready)
            begin
                seen = evt_if.data;
                if (pending_events.size() == 0)
                    report_failure($sformatf("unexpected event kind %0d byte %h len %0d",
                        seen.event_kind, seen.payload_byte, seen.frame_length));
                else
                begin
                    want = pending_events.pop_front();
                    if (seen.event_kind !== want.event_kind
                        || seen.payload_byte !== want.payload_byte
                        || seen.frame_length !== want.frame_length)
                        report_failure($sformatf({"event mismatch: exp kind %0d byte %h",
                            " len %0d, got kind %0d byte %h len %0d"},
                            want.event_kind, want.payload_byte, want.frame_length,
                            seen.event_kind, seen.payload_byte, seen.frame_length));
                end
            end
            evt_if.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // stimulus sequence
    initial
    begin
        rx_if.valid = 1'b0;
        rx_if.data = '0;
        evt_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        rst_n = 1'b0;
        cycle_count = 0;
        mismatch_count = 0;
        frame_phase = slfr_pkg::PH_SOF;
        escape_seen = 1'b0;
        frame_len = '0;
        len_left = '0;
        limit_len = slfr_pkg::MAX_LEN_RESET;
        send_idle_pct = 21;
        stall_pct = 87;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed words and random frames at the reset limit, slow receiver
        @(negedge clk);
        foreach (DIRECTED_BYTES[i])
            link_bytes.push_back(DIRECTED_BYTES[i]);
        fill_segment();
        wait_drained(4);

        // limit of one byte, slow sender
        write_max_len(16'd1);
        @(negedge clk);
        send_idle_pct = 87;
        stall_pct = 21;
        fill_segment();
        wait_drained(4);

        // largest limit, full rate both sides
        write_max_len(16'hFFFF);
        @(negedge clk);
        send_idle_pct = 0;
        stall_pct = 0;
        fill_segment();
        wait_drained(4);

        // small random limit
        write_max_len(16'($urandom_range(2, 40)));
        fill_segment();
        wait_drained(16);

        if (mismatch_count == 0 && pending_events.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

/* filelist.f */
design/slfr_pkg.sv
design/slfr_stream_if.sv
design/stuffed_length_frame_receiver_unit.sv
dv/tb.sv
